/* sv/gls_pkg.sv */
package gls_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int CELL_BITS  = 6;
	localparam int COORD_W    = CELL_BITS + FRAC_BITS;
	localparam int CELL_COUNT = 1 << (2 * CELL_BITS);
	localparam int IDX_W      = 2 * CELL_BITS;
	localparam int TOUCH_DEPTH = 256;
	localparam int TOUCH_W    = $clog2(TOUCH_DEPTH);
	localparam int COUNT_W    = TOUCH_W + 1;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// edge codes, same order as the wall bits
	localparam int EDGE_W = 0;
	localparam int EDGE_S = 1;
	localparam int EDGE_E = 2;
	localparam int EDGE_N = 3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_ADD,
		ST_DIV,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_CHK,
		ST_CHK_IDX,
		ST_CHK_EVAL,
		ST_DONE
	} state_t;

	function automatic logic [15:0] pair_bits(input int a, input int b);
		logic [15:0] r;
		r = '0;
		r[4 * a + b] = 1'b1;
		r[4 * b + a] = 1'b1;
		return r;
	endfunction

	// pass map for a freshly written cell
	function automatic logic [15:0] wall_map(input logic [3:0] walls);
		logic [15:0] m;
		m = 16'hFFFF;
		if (walls[EDGE_N])
			m &= ~(pair_bits(EDGE_N, EDGE_S) | pair_bits(EDGE_N, EDGE_E) |
			       pair_bits(EDGE_N, EDGE_W) | pair_bits(EDGE_E, EDGE_W));
		if (walls[EDGE_E])
			m &= ~(pair_bits(EDGE_E, EDGE_S) | pair_bits(EDGE_N, EDGE_E) |
			       pair_bits(EDGE_E, EDGE_W) | pair_bits(EDGE_N, EDGE_S));
		if (walls[EDGE_S])
			m &= ~(pair_bits(EDGE_N, EDGE_S) | pair_bits(EDGE_S, EDGE_E) |
			       pair_bits(EDGE_S, EDGE_W) | pair_bits(EDGE_E, EDGE_W));
		if (walls[EDGE_W])
			m &= ~(pair_bits(EDGE_W, EDGE_S) | pair_bits(EDGE_N, EDGE_W) |
			       pair_bits(EDGE_E, EDGE_W) | pair_bits(EDGE_N, EDGE_S));
		return m;
	endfunction

	// a cell with exactly two marks must pass that edge pair
	function automatic logic cell_ok(input logic [3:0] marks, input logic [15:0] pass);
		logic ok;
		ok = 1'b1;
		if ($countones(marks) == 2) begin
			for (int a = 0; a < 4; a++)
				for (int b = 0; b < 4; b++)
					if (a != b && marks[a] && marks[b] && !pass[4 * a + b])
						ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

/* sv/gls_ram.sv */
module gls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

/* sv/grid_line_of_sight.sv */
// Line-of-sight engine over a 64 x 64 grid of cells, each holding a 16-bit
// map of which edge pairs a sight line may pass. A write transaction
// (tuser = 0) replaces one cell's map from its wall bits.
// A query transaction (tuser = 1) walks every crossed row line and then every
// crossed column line; each crossing takes one multiply, a 6-step shared
// divider and two read-modify-write marks in the marks memory, then every
// touched cell takes memory reads. After reset the block sweeps both
// 4096-entry memories, one entry a cycle, and takes no transaction until
// the sweep is done. The one-bit result sits in an output register, so a
// new transaction is taken while it waits.
module grid_line_of_sight (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_line[5:0], cell_column[11:6], wall_bits[15:12], from_line[29:16],
	// from_column[43:30], to_line[57:44], to_column[71:58]
	input  logic [71:0] s_tdata,
	// req_type[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// visible[0], zero fill [7:1]
	output logic [7:0]  m_tdata
);

	localparam int CW = gls_pkg::COORD_W;
	localparam int FB = gls_pkg::FRAC_BITS;
	localparam int CB = gls_pkg::CELL_BITS;

	gls_pkg::state_t state_q, state_d;

	logic [gls_pkg::IDX_W-1:0]   clr_q;
	logic [CW-1:0]               fl_q, fc_q, tl_q, tc_q;
	logic                        phase_q;
	logic [CB:0]                 n_q;
	logic [CB-1:0]               hi_q;
	logic [31:0]                 base_q, prod_q, rem_q;
	logic [22:0]                 den_q;
	logic signed [15:0]          dos_q;
	logic [CW-1:0]               w1_q;
	logic [2:0]                  qk_q;
	logic [CB-1:0]               quo_q;
	logic                        msel_q;
	logic [gls_pkg::COUNT_W-1:0] cnt_q, k_q;
	logic [gls_pkg::IDX_W-1:0]   idx_q;
	logic                        vis_q;
	logic                        out_vld_q, out_vis_q;

	logic                        in_acc, out_load;
	logic [CW-1:0]               w1, w2, o1, o2;
	logic signed [CW:0]          dw, dwo;
	logic [CW-1:0]               dwa, lo, hi;
	logic signed [15:0]          dos, t;
	logic [31:0]                 den_sh;
	logic [gls_pkg::IDX_W-1:0]   mark_idx;
	logic [3:0]                  mark_bit;

	logic                        map_we, mk_we, tc_we;
	logic [gls_pkg::IDX_W-1:0]   map_wa, map_ra, mk_wa, mk_ra;
	logic [15:0]                 map_wd, map_rd;
	logic [3:0]                  mk_wd, mk_rd;
	logic [gls_pkg::TOUCH_W-1:0] tc_wa, tc_ra;
	logic [gls_pkg::IDX_W-1:0]   tc_rd;

	assign s_tready = (state_q == gls_pkg::ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == gls_pkg::ST_DONE) && (!out_vld_q || m_tready);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_vis_q};

	// walked axis and crossed axis for the current phase
	always_comb begin
		w1 = phase_q ? fc_q : fl_q;
		w2 = phase_q ? tc_q : tl_q;
		o1 = phase_q ? fl_q : fc_q;
		o2 = phase_q ? tl_q : tc_q;
		dw  = $signed({1'b0, w1}) - $signed({1'b0, w2});
		dwo = $signed({1'b0, o1}) - $signed({1'b0, o2});
		dwa = dw[CW] ? CW'(-dw) : dw[CW-1:0];
		dos = dw[CW] ? -16'(dwo) : 16'(dwo);
		lo  = (w1 < w2) ? w1 : w2;
		hi  = (w1 < w2) ? w2 : w1;
		t   = $signed({2'b00, n_q[CB-1:0], {FB{1'b0}}}) - $signed({2'b00, w1_q});
		den_sh = {9'd0, den_q} << qk_q;
	end

	// cell and edge for the current mark
	always_comb begin
		logic [CB-1:0] nn;
		nn = msel_q ? CB'(n_q - 1'b1) : n_q[CB-1:0];
		mark_idx = phase_q ? {quo_q, nn} : {nn, quo_q};
		mark_bit = '0;
		if (!phase_q)
			mark_bit[msel_q ? gls_pkg::EDGE_S : gls_pkg::EDGE_N] = 1'b1;
		else
			mark_bit[msel_q ? gls_pkg::EDGE_E : gls_pkg::EDGE_W] = 1'b1;
	end

	// memory port control
	always_comb begin
		map_we = 1'b0;
		map_wa = clr_q;
		map_wd = 16'hFFFF;
		mk_we  = 1'b0;
		mk_wa  = clr_q;
		mk_wd  = '0;
		mk_ra  = mark_idx;
		map_ra = tc_rd;
		tc_we  = 1'b0;
		tc_wa  = cnt_q[gls_pkg::TOUCH_W-1:0];
		tc_ra  = k_q[gls_pkg::TOUCH_W-1:0];
		if (state_q == gls_pkg::ST_CLEAR) begin
			map_we = 1'b1;
			mk_we  = 1'b1;
		end
		if (in_acc && s_tuser == gls_pkg::REQ_WRITE) begin
			map_we = 1'b1;
			map_wa = {s_tdata[5:0], s_tdata[11:6]};
			map_wd = gls_pkg::wall_map(s_tdata[15:12]);
		end
		if (state_q == gls_pkg::ST_CHK_IDX)
			mk_ra = tc_rd;
		if (state_q == gls_pkg::ST_MARK_WR) begin
			mk_we = 1'b1;
			mk_wa = mark_idx;
			mk_wd = mk_rd | mark_bit;
			tc_we = (mk_rd == 4'd0);
		end
		if (state_q == gls_pkg::ST_CHK_EVAL) begin
			mk_we = 1'b1;
			mk_wa = idx_q;
		end
	end

	gls_ram #(.WIDTH(16), .DEPTH(gls_pkg::CELL_COUNT)) u_map (
		.clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd),
		.raddr(map_ra), .rdata(map_rd)
	);

	gls_ram #(.WIDTH(4), .DEPTH(gls_pkg::CELL_COUNT)) u_marks (
		.clk(clk), .we(mk_we), .waddr(mk_wa), .wdata(mk_wd),
		.raddr(mk_ra), .rdata(mk_rd)
	);

	gls_ram #(.WIDTH(gls_pkg::IDX_W), .DEPTH(gls_pkg::TOUCH_DEPTH)) u_touched (
		.clk(clk), .we(tc_we), .waddr(tc_wa), .wdata(mark_idx),
		.raddr(tc_ra), .rdata(tc_rd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gls_pkg::ST_CLEAR:
				if (&clr_q)
					state_d = gls_pkg::ST_IDLE;
			gls_pkg::ST_IDLE:
				if (in_acc && s_tuser == gls_pkg::REQ_QUERY)
					state_d = gls_pkg::ST_SETUP;
			gls_pkg::ST_SETUP:
				state_d = gls_pkg::ST_MUL;
			gls_pkg::ST_MUL: begin
				if (n_q > {1'b0, hi_q})
					state_d = phase_q ? gls_pkg::ST_CHK : gls_pkg::ST_SETUP;
				else
					state_d = gls_pkg::ST_ADD;
			end
			gls_pkg::ST_ADD:
				state_d = gls_pkg::ST_DIV;
			gls_pkg::ST_DIV:
				if (qk_q == 3'd0)
					state_d = gls_pkg::ST_MARK_RD;
			gls_pkg::ST_MARK_RD:
				state_d = gls_pkg::ST_MARK_WR;
			gls_pkg::ST_MARK_WR:
				state_d = msel_q ? gls_pkg::ST_MUL : gls_pkg::ST_MARK_RD;
			gls_pkg::ST_CHK:
				state_d = (k_q == cnt_q) ? gls_pkg::ST_DONE : gls_pkg::ST_CHK_IDX;
			gls_pkg::ST_CHK_IDX:
				state_d = gls_pkg::ST_CHK_EVAL;
			gls_pkg::ST_CHK_EVAL:
				state_d = gls_pkg::ST_CHK;
			gls_pkg::ST_DONE:
				if (out_load)
					state_d = gls_pkg::ST_IDLE;
			default:
				state_d = gls_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= gls_pkg::ST_CLEAR;
			clr_q     <= '0;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
			phase_q   <= 1'b0;
			msel_q    <= 1'b0;
			k_q       <= '0;
			qk_q      <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == gls_pkg::ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (in_acc) begin
				phase_q <= 1'b0;
				k_q     <= '0;
			end
			if (state_q == gls_pkg::ST_MUL && n_q > {1'b0, hi_q})
				phase_q <= 1'b1;
			if (state_q == gls_pkg::ST_ADD)
				qk_q <= 3'(CB - 1);
			if (state_q == gls_pkg::ST_DIV)
				qk_q <= qk_q - 1'b1;
			if (state_q == gls_pkg::ST_MARK_WR) begin
				msel_q <= !msel_q;
				if (tc_we)
					cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == gls_pkg::ST_CHK_EVAL)
				k_q <= k_q + 1'b1;
			if (out_load)
				cnt_q <= '0;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			fl_q  <= s_tdata[29:16];
			fc_q  <= s_tdata[43:30];
			tl_q  <= s_tdata[57:44];
			tc_q  <= s_tdata[71:58];
			vis_q <= 1'b1;
		end
		if (state_q == gls_pkg::ST_SETUP) begin
			n_q    <= (CB + 1)'(lo[CW-1:FB]) + 1'b1;
			hi_q   <= hi[CW-1:FB];
			base_q <= 32'(o1 * dwa);
			den_q  <= {1'b0, dwa[CW-1:0], {FB{1'b0}}};
			dos_q  <= dos;
			w1_q   <= w1;
		end
		if (state_q == gls_pkg::ST_MUL)
			prod_q <= 32'(t * dos_q);
		if (state_q == gls_pkg::ST_ADD) begin
			rem_q <= base_q + prod_q;
			quo_q <= '0;
		end
		// restoring divide, one quotient bit a cycle
		if (state_q == gls_pkg::ST_DIV && rem_q >= den_sh) begin
			rem_q        <= rem_q - den_sh;
			quo_q[qk_q]  <= 1'b1;
		end
		if (state_q == gls_pkg::ST_MARK_WR && msel_q)
			n_q <= n_q + 1'b1;
		if (state_q == gls_pkg::ST_CHK_IDX)
			idx_q <= tc_rd;
		if (state_q == gls_pkg::ST_CHK_EVAL && !gls_pkg::cell_ok(mk_rd, map_rd))
			vis_q <= 1'b0;
		if (out_load)
			out_vis_q <= vis_q;
	end

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gls_pkg::COUNT_W'(gls_pkg::TOUCH_DEPTH))
		else $error("touched count overflow");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gls_pkg::ST_IDLE |-> cnt_q == '0)
		else $error("touched list not emptied after query");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gls_pkg::ST_CLEAR |-> !s_tready)
		else $error("transaction taken during memory sweep");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("query result not presented");

	a_chk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gls_pkg::ST_CHK_IDX |-> k_q < cnt_q)
		else $error("touched list read past its end");

endmodule

/* verif/grid_line_of_sight_tb.sv */
module grid_line_of_sight_tb;

	localparam int LINES = 1 << gls_pkg::CELL_BITS;
	localparam int ONE   = 1 << gls_pkg::FRAC_BITS;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;

	// expected visibility flags, oldest first
	logic        visible_queue[$];
	logic [15:0] pass_map[gls_pkg::CELL_COUNT];
	int          error_count;
	int          send_idle_pct;
	int          recv_stall_pct;

	grid_line_of_sight u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// pass map for a freshly written cell, per wall bit
	function automatic logic [15:0] walls_to_map(input logic [3:0] walls);
		logic [15:0] m;
		m = 16'hFFFF;
		if (walls[3]) m &= ~16'b0111_1001_1000_1100;
		if (walls[2]) m &= ~16'b0110_1011_1100_0100;
		if (walls[1]) m &= ~16'b0010_0011_1101_0110;
		if (walls[0]) m &= ~16'b0011_0001_1001_1110;
		return m;
	endfunction

	function automatic longint floor_quot(input longint num, input longint den);
		longint q;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q--;
		return q;
	endfunction

	// walk both line families, collect marks per cell, check two-mark cells
	function automatic logic sight_clear(input longint l1, c1, l2, c2);
		logic [3:0] marks[int];
		longint dl, dc, lo, hi, n, p;
		logic vis;
		int idx, a, b;
		dl = l1 - l2;
		dc = c1 - c2;
		vis = 1'b1;
		lo = (l1 < l2) ? l1 : l2;
		hi = (l1 < l2) ? l2 : l1;
		for (n = (lo >>> gls_pkg::FRAC_BITS) + 1; n <= (hi >>> gls_pkg::FRAC_BITS); n++) begin
			p = floor_quot(c1 * dl + (n * ONE - l1) * dc, ONE * dl);
			if (p >= 0 && p < LINES) begin
				if (n < LINES) begin
					idx = int'(n * LINES + p);
					marks[idx] = (marks.exists(idx) ? marks[idx] : 4'd0) | 4'b1000;
				end
				idx = int'((n - 1) * LINES + p);
				marks[idx] = (marks.exists(idx) ? marks[idx] : 4'd0) | 4'b0010;
			end
		end
		lo = (c1 < c2) ? c1 : c2;
		hi = (c1 < c2) ? c2 : c1;
		for (n = (lo >>> gls_pkg::FRAC_BITS) + 1; n <= (hi >>> gls_pkg::FRAC_BITS); n++) begin
			p = floor_quot(l1 * dc + (n * ONE - c1) * dl, ONE * dc);
			if (p >= 0 && p < LINES) begin
				if (n < LINES) begin
					idx = int'(p * LINES + n);
					marks[idx] = (marks.exists(idx) ? marks[idx] : 4'd0) | 4'b0001;
				end
				idx = int'(p * LINES + n - 1);
				marks[idx] = (marks.exists(idx) ? marks[idx] : 4'd0) | 4'b0100;
			end
		end
		foreach (marks[i]) begin
			if ($countones(marks[i]) == 2) begin
				a = 0;
				while (!marks[i][a]) a++;
				b = a + 1;
				while (!marks[i][b]) b++;
				if (!pass_map[i][4 * a + b])
					vis = 1'b0;
			end
		end
		return vis;
	endfunction

	// send one transaction and update the predicted state
	task automatic send_item(input logic req, input logic [5:0] row, col,
			input logic [3:0] walls, input logic [13:0] fl, fc, tl, tc);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {tc, tl, fc, fl, walls, col, row};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (req == gls_pkg::REQ_WRITE)
			pass_map[{row, col}] = walls_to_map(walls);
		else
			visible_queue.push_back(sight_clear(fl, fc, tl, tc));
	endtask

	task automatic send_write(input int row, col, walls);
		send_item(gls_pkg::REQ_WRITE, 6'(row), 6'(col), 4'(walls), 14'($urandom),
			14'($urandom), 14'($urandom), 14'($urandom));
	endtask

	task automatic send_query(input int fl, fc, tl, tc);
		send_item(gls_pkg::REQ_QUERY, 6'($urandom), 6'($urandom), 4'($urandom), 14'(fl),
			14'(fc), 14'(tl), 14'(tc));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (visible_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver stalls and result check
	always @(posedge clk) begin
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_tvalid && m_tready) begin
				if (visible_queue.size() == 0) begin
					$error("visible: no result expected, actual %0d", m_tdata[0]);
					error_count++;
				end else begin
					if (m_tdata[0] !== visible_queue[0]) begin
						$error("visible: expected %0d actual %0d", visible_queue[0],
							m_tdata[0]);
						error_count++;
					end
					void'(visible_queue.pop_front());
				end
			end
		end
	end

	// corners, walls, grid-line ends and degenerate lines
	task automatic test_directed();
		send_query(0, 0, 0, 0);
		send_query(14'h3FFF, 14'h3FFF, 0, 0);
		send_write(0, 0, 4'hF);
		send_write(63, 63, 4'hF);
		send_query(14'h3FFF, 14'h3FFF, 0, 0);
		send_write(2, 3, 4'b1000);
		send_query(1 * ONE + 128, 3 * ONE + 128, 4 * ONE + 128, 3 * ONE + 128);
		send_write(2, 3, 4'b0100);
		send_query(2 * ONE + 128, 1 * ONE + 128, 2 * ONE + 128, 6 * ONE + 128);
		send_write(2, 3, 4'b0010);
		send_query(2 * ONE + 128, 3 * ONE + 128, 5 * ONE + 128, 3 * ONE + 128);
		send_write(2, 3, 4'b0001);
		send_query(2 * ONE + 128, 0, 2 * ONE + 128, 3 * ONE + 100);
		send_query(2 * ONE, 3 * ONE + 10, 3 * ONE, 3 * ONE + 10);
		send_query(1 * ONE, 1 * ONE, 4 * ONE, 5 * ONE);
		send_query(2 * ONE + 10, 2 * ONE + 20, 4 * ONE + 50, 5 * ONE + 7);
		send_write(2, 3, 4'b0000);
		send_query(14'h2AAA, 14'h1555, 14'h1555, 14'h2AAA);
		send_query(14'h3FFF, 0, 0, 14'h3FFF);
		drain_results();
	endtask

	// random walls over the whole grid and mostly short queries, some of any length
	task automatic test_random(input int count);
		logic [13:0] fl, fc;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(2) == 0)
				send_write($urandom_range(63), $urandom_range(63), $urandom_range(15));
			else if ($urandom_range(9) == 0)
				send_query($urandom, $urandom, $urandom, $urandom);
			else begin
				fl = 14'($urandom);
				fc = 14'($urandom);
				send_query(fl, fc, fl + $urandom_range(1535) - 768,
					fc + $urandom_range(1535) - 768);
			end
		end
	endtask

	initial begin
		error_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tuser        = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		foreach (pass_map[i]) pass_map[i] = 16'hFFFF;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(250);
		send_idle_pct = 52;
		test_random(250);
		drain_results();
		send_idle_pct  = 0;
		recv_stall_pct = 52;
		test_random(250);
		send_idle_pct = 18;
		recv_stall_pct = 18;
		test_random(250);
		drain_results();
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#100000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
sv/gls_pkg.sv
sv/gls_ram.sv
sv/grid_line_of_sight.sv
verif/grid_line_of_sight_tb.sv
